// ===== sv/sed_pkg.sv =====
// ----------------------------------------------------------------------------
// sed_pkg: shared types and constants of the snore event detector
// Field widths, register indexes, the block descriptor and back-end states.
// ----------------------------------------------------------------------------
`default_nettype none

package sed_pkg;

	localparam int SMP_W      = 16;
	localparam int SQ_W       = 48;
	localparam int CNT_W      = 13;
	localparam int CROSS_W    = 12;
	localparam int LVL_W      = 16;
	localparam int EVB_W      = 8;
	localparam int QB_W       = 4;
	localparam int ESUM_W     = 24;
	localparam int LTOT_W     = 48;
	localparam int BTOT_W     = 32;
	localparam int PCT_W      = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int DIV_STEPS  = 48;
	localparam int SQRT_STEPS = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CROSSING_LIMIT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_QUIET_CLOSE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_EVENT       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_EVENT       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PEAK_FACTOR     = 3'd5;

	typedef struct packed {
		logic [LVL_W-1:0] level_threshold;
		logic [PCT_W-1:0] crossing_limit_pct;
		logic [QB_W-1:0]  quiet_blocks_to_close;
		logic [EVB_W-1:0] min_event_blocks;
		logic [EVB_W-1:0] max_event_blocks;
		logic [7:0]       peak_factor_tenths;
	} cfg_t;

	typedef struct packed {
		logic [SQ_W-1:0]    sq_sum;
		logic [CNT_W-1:0]   count;
		logic [CROSS_W-1:0] crossings;
		logic               rec_end;
	} block_t;

	typedef struct packed {
		logic   avail;
		block_t data;
	} queue_rd_t;

	typedef enum logic [3:0] {
		BK_IDLE, BK_DIV, BK_SQRT, BK_UPDATE, BK_DECIDE,
		BK_JDIV, BK_JUDGE, BK_FDIV, BK_EMIT
	} back_state_t;

endpackage

`default_nettype wire

// ===== sv/sed_front.sv =====
// ----------------------------------------------------------------------------
// sed_front: sample accumulator
// Sums squares, counts sign crossings and closes blocks into descriptors.
// ----------------------------------------------------------------------------
`default_nettype none

module sed_front #(
	parameter int BLOCK_SAMPLES = 512
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             in_valid,
	output logic                            in_stall,
	input  wire  signed [sed_pkg::SMP_W-1:0] sample,
	input  wire                             block_end,
	input  wire                             recording_end,
	input  wire                             q_full,
	output logic                            q_push,
	output sed_pkg::block_t                 q_data
);
	import sed_pkg::*;

	logic [SQ_W-1:0]    sq_sum_q;
	logic [CNT_W-1:0]   count_q;
	logic               prev_neg_q;
	logic [CROSS_W-1:0] cross_q;

	logic signed [31:0] prod;
	logic [SQ_W-1:0]    sum_new;
	logic [CNT_W-1:0]   count_new;
	logic [CROSS_W-1:0] cross_new;
	logic               accept;
	logic               blk_done;

	always_comb begin
		prod      = sample * sample;
		sum_new   = sq_sum_q + SQ_W'(unsigned'(prod));
		count_new = count_q + CNT_W'(1);
		cross_new = cross_q + CROSS_W'((count_q != '0) && (sample[SMP_W-1] != prev_neg_q));
		blk_done  = block_end | recording_end | (count_new >= CNT_W'(BLOCK_SAMPLES));
		in_stall  = q_full;
		accept    = in_valid & ~q_full;
		q_push    = accept & blk_done;
		q_data    = '{sq_sum: sum_new, count: count_new, crossings: cross_new,
			rec_end: recording_end};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_sum_q   <= '0;
			count_q    <= '0;
			prev_neg_q <= 1'b0;
			cross_q    <= '0;
		end else if (accept) begin
			if (blk_done) begin
				sq_sum_q   <= '0;
				count_q    <= '0;
				prev_neg_q <= 1'b0;
				cross_q    <= '0;
			end else begin
				sq_sum_q   <= sum_new;
				count_q    <= count_new;
				prev_neg_q <= sample[SMP_W-1];
				cross_q    <= cross_new;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/sed_queue.sv =====
// ----------------------------------------------------------------------------
// sed_queue: two-entry block descriptor queue
// Decouples the sample front end from the block back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sed_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  sed_pkg::block_t     wr_data,
	input  wire                 pop,
	output logic                full,
	output sed_pkg::queue_rd_t  rd
);
	import sed_pkg::*;

	block_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	always_comb begin
		full     = (cnt_q == 2'd2);
		rd.avail = (cnt_q != 2'd0);
		rd.data  = mem_q[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

`default_nettype wire

// ===== sv/sed_div.sv =====
// ----------------------------------------------------------------------------
// sed_div: shared restoring divider
// One quotient bit a cycle from start until done.
// ----------------------------------------------------------------------------
`default_nettype none

module sed_div (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire  [sed_pkg::SQ_W-1:0]     dividend,
	input  wire  [sed_pkg::BTOT_W-1:0]   divisor,
	output logic                         done,
	output logic [sed_pkg::SQ_W-1:0]     quotient
);
	import sed_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [5:0]        step_q;
	logic [BTOT_W:0]   rem_q;
	logic [SQ_W-1:0]   quo_q;
	logic [BTOT_W-1:0] dsr_q;
	logic [BTOT_W:0]   rem_sh;
	logic              fits;

	always_comb begin
		rem_sh   = {rem_q[BTOT_W-1:0], quo_q[SQ_W-1]};
		fits     = rem_sh >= {1'b0, dsr_q};
		done     = done_q;
		quotient = quo_q;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sh - {1'b0, dsr_q} : rem_sh;
			quo_q <= {quo_q[SQ_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 6'd1;
				if (step_q == 6'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/sed_back.sv =====
// ----------------------------------------------------------------------------
// sed_back: block evaluation back end
// Level by division and square root, event tracking, snore judgement.
// ----------------------------------------------------------------------------
`default_nettype none

module sed_back (
	input  wire                            clk,
	input  wire                            arst_n,
	input  sed_pkg::cfg_t                  cfg,
	input  sed_pkg::queue_rd_t             q_rd,
	output logic                           q_pop,
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic [sed_pkg::LVL_W-1:0]      block_level,
	output logic [sed_pkg::CROSS_W-1:0]    block_crossings,
	output logic                           block_suspicious,
	output logic                           event_open,
	output logic [15:0]                    snore_count,
	output logic                           final_res,
	output logic [sed_pkg::LVL_W-1:0]      mean_level,
	output logic [sed_pkg::LVL_W-1:0]      max_level,
	output logic                           snore_found
);
	import sed_pkg::*;

	back_state_t state_q, state_nx;

	logic               div_start;
	logic [SQ_W-1:0]    div_dividend;
	logic [BTOT_W-1:0]  div_divisor;
	logic               div_done;
	logic [SQ_W-1:0]    div_quo;

	logic [CNT_W-1:0]   count_q;
	logic [CROSS_W-1:0] cross_q;
	logic               final_q;
	logic [SQ_W-1:0]    rad_q;
	logic [25:0]        rem_q;
	logic [23:0]        root_q;
	logic [4:0]         sq_step_q;
	logic [LVL_W-1:0]   level_q;
	logic               susp_q;
	logic               judge_q;
	logic [LVL_W-1:0]   mean_q;
	logic [LTOT_W-1:0]  ltot_q;
	logic [BTOT_W-1:0]  btot_q;
	logic [LVL_W-1:0]   opeak_q;
	logic               in_event_q;
	logic [EVB_W-1:0]   evb_q;
	logic [QB_W-1:0]    quiet_q;
	logic [LVL_W-1:0]   epeak_q;
	logic [ESUM_W-1:0]  esum_q;
	logic [15:0]        snores_q;
	logic               out_load;

	logic [25:0]        sq_rem_sh;
	logic [25:0]        sq_trial;
	logic [LVL_W-1:0]   level;
	logic               susp;
	logic [EVB_W-1:0]   evb_base;
	logic [LVL_W-1:0]   epeak_base;
	logic [ESUM_W-1:0]  esum_base;
	logic [QB_W-1:0]    quiet_inc;
	logic [ESUM_W-1:0]  ev_mean;
	logic               snore_ok;
	logic               fdiv_needed;

	sed_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		sq_rem_sh  = {rem_q[23:0], rad_q[SQ_W-1 -: 2]};
		sq_trial   = {root_q, 2'b01};
		level      = root_q[LVL_W-1:0];
		susp       = (count_q > CNT_W'(1)) && (level > cfg.level_threshold) &&
			((20'(cross_q) * 20'd100) < (20'(cfg.crossing_limit_pct) * 20'(count_q)));
		evb_base   = in_event_q ? evb_q : '0;
		epeak_base = in_event_q ? epeak_q : '0;
		esum_base  = in_event_q ? esum_q : '0;
		quiet_inc  = quiet_q + QB_W'(1);
		ev_mean    = div_quo[ESUM_W-1:0];
		snore_ok   = (evb_q >= cfg.min_event_blocks) && (evb_q <= cfg.max_event_blocks) &&
			(evb_q != '0) && (ev_mean != '0) &&
			(32'(epeak_q) * 32'd10 < 32'(ev_mean) * 32'(cfg.peak_factor_tenths));
		fdiv_needed = final_q && (btot_q != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= BK_IDLE;
		else
			state_q <= state_nx;
	end

	always_comb begin
		state_nx     = state_q;
		q_pop        = 1'b0;
		div_start    = 1'b0;
		div_dividend = q_rd.data.sq_sum;
		div_divisor  = BTOT_W'(q_rd.data.count);
		out_load     = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (q_rd.avail) begin
					q_pop     = 1'b1;
					div_start = 1'b1;
					state_nx  = BK_DIV;
				end
			end
			BK_DIV: begin
				if (div_done)
					state_nx = BK_SQRT;
			end
			BK_SQRT: begin
				if (sq_step_q == 5'(SQRT_STEPS - 1))
					state_nx = BK_UPDATE;
			end
			BK_UPDATE: state_nx = BK_DECIDE;
			BK_DECIDE: begin
				if (judge_q) begin
					div_start    = 1'b1;
					div_dividend = SQ_W'(esum_q);
					div_divisor  = BTOT_W'(evb_q);
					state_nx     = BK_JDIV;
				end else if (fdiv_needed) begin
					div_start    = 1'b1;
					div_dividend = ltot_q;
					div_divisor  = btot_q;
					state_nx     = BK_FDIV;
				end else begin
					state_nx = BK_EMIT;
				end
			end
			BK_JDIV: begin
				if (div_done)
					state_nx = BK_JUDGE;
			end
			BK_JUDGE: begin
				if (fdiv_needed) begin
					div_start    = 1'b1;
					div_dividend = ltot_q;
					div_divisor  = btot_q;
					state_nx     = BK_FDIV;
				end else begin
					state_nx = BK_EMIT;
				end
			end
			BK_FDIV: begin
				if (div_done)
					state_nx = BK_EMIT;
			end
			BK_EMIT: begin
				if (!out_valid || !out_stall) begin
					out_load = 1'b1;
					state_nx = BK_IDLE;
				end
			end
			default: state_nx = BK_IDLE;
		endcase
	end

	// working registers of one block
	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				count_q <= q_rd.data.count;
				cross_q <= q_rd.data.crossings;
				final_q <= q_rd.data.rec_end;
			end
			BK_DIV: begin
				rad_q     <= div_quo;
				rem_q     <= '0;
				root_q    <= '0;
				sq_step_q <= '0;
			end
			BK_SQRT: begin
				rad_q     <= {rad_q[SQ_W-3:0], 2'b00};
				sq_step_q <= sq_step_q + 5'd1;
				if (sq_rem_sh >= sq_trial) begin
					rem_q  <= sq_rem_sh - sq_trial;
					root_q <= {root_q[22:0], 1'b1};
				end else begin
					rem_q  <= sq_rem_sh;
					root_q <= {root_q[22:0], 1'b0};
				end
			end
			BK_UPDATE: begin
				level_q <= level;
				susp_q  <= susp;
				mean_q  <= '0;
			end
			BK_FDIV: mean_q <= div_quo[LVL_W-1:0];
			default: ;
		endcase
	end

	// recording and event state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ltot_q     <= '0;
			btot_q     <= '0;
			opeak_q    <= '0;
			in_event_q <= 1'b0;
			evb_q      <= '0;
			quiet_q    <= '0;
			epeak_q    <= '0;
			esum_q     <= '0;
			snores_q   <= '0;
			judge_q    <= 1'b0;
		end else begin
			case (state_q)
				BK_UPDATE: begin
					judge_q <= 1'b0;
					if (btot_q != '1) begin
						ltot_q <= ltot_q + LTOT_W'(level);
						btot_q <= btot_q + BTOT_W'(1);
					end
					if (level > opeak_q)
						opeak_q <= level;
					if (susp) begin
						in_event_q <= 1'b1;
						quiet_q    <= '0;
						evb_q      <= evb_base;
						esum_q     <= esum_base;
						if (evb_base != '1) begin
							evb_q  <= evb_base + EVB_W'(1);
							esum_q <= esum_base + ESUM_W'(level);
						end
						epeak_q <= (level > epeak_base) ? level : epeak_base;
						judge_q <= final_q;
					end else if (in_event_q) begin
						quiet_q <= quiet_inc;
						judge_q <= final_q || (quiet_inc >= cfg.quiet_blocks_to_close);
					end
				end
				BK_JUDGE: begin
					if (snore_ok && snores_q != '1)
						snores_q <= snores_q + 16'd1;
					in_event_q <= 1'b0;
					evb_q      <= '0;
					quiet_q    <= '0;
					epeak_q    <= '0;
					esum_q     <= '0;
					judge_q    <= 1'b0;
				end
				BK_EMIT: begin
					if (out_load && final_q) begin
						ltot_q     <= '0;
						btot_q     <= '0;
						opeak_q    <= '0;
						in_event_q <= 1'b0;
						evb_q      <= '0;
						quiet_q    <= '0;
						epeak_q    <= '0;
						esum_q     <= '0;
						snores_q   <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (out_load)
			out_valid <= 1'b1;
		else if (!out_stall)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			block_level      <= level_q;
			block_crossings  <= cross_q;
			block_suspicious <= susp_q;
			event_open       <= final_q ? 1'b0 : in_event_q;
			snore_count      <= snores_q;
			final_res        <= final_q;
			mean_level       <= mean_q;
			max_level        <= opeak_q;
			snore_found      <= final_q && (snores_q != '0);
		end
	end

	a_final_closed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && final_res |-> !event_open)
		else $error("event left open on final beat");

	a_found_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && snore_found |-> final_res && (snore_count != '0))
		else $error("snore_found without final beat");

	a_peak_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> max_level >= block_level)
		else $error("max_level below block_level");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> block_level <= 16'h8000)
		else $error("block_level out of range");

endmodule

`default_nettype wire

// ===== sv/snore_event_detector.sv =====
// ----------------------------------------------------------------------------
// snore_event_detector: block level snore event detector
// Audio samples in, one result beat per finished analysis block out.
// ----------------------------------------------------------------------------
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------
//  in       | in_valid / in_stall   | sample, block_end, recording_end
//  out      | out_valid / out_stall | block_level ... snore_found
//  cfg      | cfg_we                | cfg_index, cfg_data
//
// The front end takes one sample beat per cycle while the descriptor queue
// (two blocks deep) has room. For each block the back end divides, takes the
// square root and updates; it divides again when an event is judged and once
// more for the mean on the final block, all on the one shared bit-serial
// divider. Short blocks can stall the input while the queue is full.
// Reset clears all counters and loads the register defaults; no clearing pass.
// A held out_stall keeps the result register full; the back end then waits.
//
`default_nettype none

module snore_event_detector #(
	parameter int BLOCK_SAMPLES = 512
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_stall,
	input  wire  signed [sed_pkg::SMP_W-1:0]    sample,
	input  wire                                 block_end,
	input  wire                                 recording_end,
	output logic                                out_valid,
	input  wire                                 out_stall,
	output logic [sed_pkg::LVL_W-1:0]           block_level,
	output logic [sed_pkg::CROSS_W-1:0]         block_crossings,
	output logic                                block_suspicious,
	output logic                                event_open,
	output logic [15:0]                         snore_count,
	output logic                                final_res,
	output logic [sed_pkg::LVL_W-1:0]           mean_level,
	output logic [sed_pkg::LVL_W-1:0]           max_level,
	output logic                                snore_found,
	input  wire                                 cfg_we,
	input  wire  [sed_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [sed_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import sed_pkg::*;

	cfg_t      cfg_q;
	logic      q_full;
	logic      q_push;
	logic      q_pop;
	block_t    q_wr;
	queue_rd_t q_rd;

	// configuration registers: hold reset defaults until written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.level_threshold       <= 16'd700;
			cfg_q.crossing_limit_pct    <= 7'd18;
			cfg_q.quiet_blocks_to_close <= 4'd4;
			cfg_q.min_event_blocks      <= 8'd4;
			cfg_q.max_event_blocks      <= 8'd45;
			cfg_q.peak_factor_tenths    <= 8'd26;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LEVEL_THRESHOLD: cfg_q.level_threshold       <= cfg_data;
				CFG_CROSSING_LIMIT:  cfg_q.crossing_limit_pct    <= cfg_data[PCT_W-1:0];
				CFG_QUIET_CLOSE:     cfg_q.quiet_blocks_to_close <= cfg_data[QB_W-1:0];
				CFG_MIN_EVENT:       cfg_q.min_event_blocks      <= cfg_data[EVB_W-1:0];
				CFG_MAX_EVENT:       cfg_q.max_event_blocks      <= cfg_data[EVB_W-1:0];
				CFG_PEAK_FACTOR:     cfg_q.peak_factor_tenths    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// front: accumulate samples, close blocks
	sed_front #(
		.BLOCK_SAMPLES (BLOCK_SAMPLES)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.sample        (sample),
		.block_end     (block_end),
		.recording_end (recording_end),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_data        (q_wr)
	);

	// queue: decouple the two sides
	sed_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (q_wr),
		.pop     (q_pop),
		.full    (q_full),
		.rd      (q_rd)
	);

	// back: evaluate blocks, track events, drive result beats
	sed_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.q_rd             (q_rd),
		.q_pop            (q_pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.block_level      (block_level),
		.block_crossings  (block_crossings),
		.block_suspicious (block_suspicious),
		.event_open       (event_open),
		.snore_count      (snore_count),
		.final_res        (final_res),
		.mean_level       (mean_level),
		.max_level        (max_level),
		.snore_found      (snore_found)
	);

endmodule

`default_nettype wire
